### rtl/pfrp_pkg.sv
// Shared types and codes for the paged framebuffer rectangle plotter.
// No dependencies.
package pfrp_pkg;

  typedef enum logic [1:0] {
    CMD_DOT   = 2'd0,
    CMD_RECT  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_code_t;

  localparam logic [1:0] COLOR_NONE      = 2'd0;
  localparam logic [1:0] COLOR_WHITE     = 2'd1;
  localparam logic [1:0] COLOR_BLACK     = 2'd2;
  // spare code, paints as black
  localparam logic [1:0] COLOR_BLACK_ALT = 2'd3;

  localparam logic [2:0] REG_PEN_COL     = 3'd0;
  localparam logic [2:0] REG_PEN_WIDTH   = 3'd1;
  localparam logic [2:0] REG_FILL_COL    = 3'd2;
  localparam logic [2:0] REG_CLIP_LEFT   = 3'd3;
  localparam logic [2:0] REG_CLIP_TOP    = 3'd4;
  localparam logic [2:0] REG_CLIP_WIDTH  = 3'd5;
  localparam logic [2:0] REG_CLIP_HEIGHT = 3'd6;

  // box selector: which painted box of a request is being prepared
  localparam logic [2:0] SEL_DOT    = 3'd0;
  localparam logic [2:0] SEL_LEFT   = 3'd1;
  localparam logic [2:0] SEL_RIGHT  = 3'd2;
  localparam logic [2:0] SEL_TOP    = 3'd3;
  localparam logic [2:0] SEL_BOTTOM = 3'd4;
  localparam logic [2:0] SEL_FILL   = 3'd5;

  typedef struct packed {
    logic       accept;
    logic       load_raw;
    logic [2:0] box_sel;
    logic       load_box;
    logic       load_full;
    logic       mem_rd;
    logic       mem_wr;
    logic       wr_zero;
    logic       advance;
    logic       rd_byte;
  } dp_cmd_t;

  typedef struct packed {
    logic box_empty;
    logic walk_last;
  } dp_status_t;

endpackage

### rtl/paged_framebuffer_rect_plotter_top.sv
// Top level of the paged framebuffer rectangle plotter.
// Depends on pfrp_pkg, pfrp_controller, pfrp_datapath.
//
// Monochrome framebuffer of SCREEN_COLUMNS x SCREEN_ROWS in page layout (one
// byte per column per 8-row page). A request is taken when start is high and
// busy low; each request answers with a single out_strobe cycle that the
// receiver must take at once. Drawing is a byte-wise read-modify-write on
// the single-port buffer memory (a read then a write per touched byte),
// after a box setup of raw box, clamp and clip, then empty check for each
// box (one for a dot, five for a rectangle: four frame edges then the fill).
// A clear writes one byte a cycle, all SCREEN_COLUMNS*ceil(SCREEN_ROWS/8)
// bytes (1024 at defaults). After reset the same clearing pass runs with
// busy high; config writes are taken throughout. Config writes are always
// ready and must be issued only while the block is idle.
module paged_framebuffer_rect_plotter_top #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [11:0] in_pos_x,
  input  logic signed [11:0] in_pos_y,
  input  logic [10:0]        in_rect_width,
  input  logic [10:0]        in_rect_height,
  input  logic [9:0]         in_byte_address,
  output logic               out_strobe,
  output logic [7:0]         out_read_data,
  output logic               out_finished,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import pfrp_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // registers accept writes in any cycle
  assign cfg_ready = 1'b1;
  // every request completes
  assign out_finished = 1'b1;

  pfrp_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (dp_cmd),
    .status     (dp_status)
  );

  pfrp_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .status          (dp_status),
    .cfg_valid       (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_command      (in_command),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_rect_width   (in_rect_width),
    .in_rect_height  (in_rect_height),
    .in_byte_address (in_byte_address),
    .out_read_data   (out_read_data)
  );

endmodule

### rtl/pfrp_datapath.sv
// Datapath: config registers, box setup, byte walk and framebuffer memory.
// Depends on pfrp_pkg.
module pfrp_datapath #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfrp_pkg::dp_cmd_t    cmd,
  output pfrp_pkg::dp_status_t status,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [11:0]          cfg_data,
  input  logic [1:0]           in_command,
  input  logic signed [11:0]   in_pos_x,
  input  logic signed [11:0]   in_pos_y,
  input  logic [10:0]          in_rect_width,
  input  logic [10:0]          in_rect_height,
  input  logic [9:0]           in_byte_address,
  output logic [7:0]           out_read_data
);
  import pfrp_pkg::*;

  localparam int PAGES  = (SCREEN_ROWS + 7) / 8;
  localparam int BYTES  = SCREEN_COLUMNS * PAGES;
  localparam int AW     = $clog2(BYTES);
  localparam int RAW_W  = (AW > 10) ? AW : 10;
  localparam int CW     = $clog2(SCREEN_COLUMNS);
  localparam int RW     = $clog2(SCREEN_ROWS);
  localparam int PW     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic signed [13:0] XMAX = 14'(SCREEN_COLUMNS - 1);
  localparam logic signed [13:0] YMAX = 14'(SCREEN_ROWS - 1);

  // config registers
  logic [1:0]         pen_col_r, fill_col_r;
  logic [7:0]         pen_width_r;
  logic signed [11:0] clip_left_r, clip_top_r;
  logic [10:0]        clip_width_r, clip_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_col_r     <= COLOR_WHITE;
      pen_width_r   <= 8'd1;
      fill_col_r    <= COLOR_NONE;
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_width_r  <= '0;
      clip_height_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PEN_COL:     pen_col_r     <= cfg_data[1:0];
        REG_PEN_WIDTH:   pen_width_r   <= cfg_data[7:0];
        REG_FILL_COL:    fill_col_r    <= cfg_data[1:0];
        REG_CLIP_LEFT:   clip_left_r   <= cfg_data;
        REG_CLIP_TOP:    clip_top_r    <= cfg_data;
        REG_CLIP_WIDTH:  clip_width_r  <= cfg_data[10:0];
        REG_CLIP_HEIGHT: clip_height_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // latched request
  logic signed [11:0] px_r, py_r;
  logic [10:0]        w_r, h_r;
  logic [9:0]         addr_r;
  logic               rd_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else if (cmd.accept) begin
      rd_ok_r <= (in_command == CMD_READ) && (32'(in_byte_address) < BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      w_r    <= in_rect_width;
      h_r    <= in_rect_height;
      addr_r <= in_byte_address;
    end
  end

  // stage 1: raw box
  logic signed [13:0] px, py, xr, yb, pxc, pyc, lead, trail;
  logic signed [13:0] cx0, cx1, cy0, cy1;
  logic signed [13:0] bx0, bx1, by0, by1;
  logic               stamp, en, rect_ok;
  logic [1:0]         bcol;

  always_comb begin
    px      = 14'(px_r);
    py      = 14'(py_r);
    xr      = px + 14'(w_r) - 14'sd1;
    yb      = py + 14'(h_r) - 14'sd1;
    pxc     = (px < 0) ? 14'sd0 : px;
    pyc     = (py < 0) ? 14'sd0 : py;
    rect_ok = (w_r != 0) && (h_r != 0);
    trail   = 14'(pen_width_r[7:1]);
    lead    = pen_width_r[0] ? trail : trail - 14'sd1;
    cx0 = px; cx1 = px; cy0 = py; cy1 = py;
    stamp = 1'b1;
    en    = 1'b1;
    case (cmd.box_sel)
      SEL_DOT: ;
      SEL_LEFT: begin
        cy0 = pyc; cy1 = yb;
        en  = rect_ok && (px >= 0) && (px <= XMAX);
      end
      SEL_RIGHT: begin
        cx0 = xr; cx1 = xr; cy0 = pyc; cy1 = yb;
        en  = rect_ok && (xr >= 0) && (xr <= XMAX);
      end
      SEL_TOP: begin
        cx0 = pxc; cx1 = xr;
        en  = rect_ok && (py >= 0) && (py <= YMAX);
      end
      SEL_BOTTOM: begin
        cx0 = pxc; cx1 = xr; cy0 = yb; cy1 = yb;
        en  = rect_ok && (yb >= 0) && (yb <= YMAX);
      end
      default: begin
        cx1 = xr; cy1 = yb; stamp = 1'b0; en = rect_ok;
      end
    endcase
    if (stamp) begin
      en   = en && (pen_col_r != COLOR_NONE) && (pen_width_r != 0) &&
             (cx0 <= cx1) && (cy0 <= cy1);
      bx0  = cx0 - lead;  bx1 = cx1 + trail;
      by0  = cy0 - lead;  by1 = cy1 + trail;
      bcol = pen_col_r;
    end else begin
      bx0 = cx0; bx1 = cx1; by0 = cy0; by1 = cy1;
      bcol = fill_col_r;
    end
  end

  logic signed [13:0] rx0_r, rx1_r, ry0_r, ry1_r;
  logic [1:0]         rcol_r;
  logic               ren_r;

  always_ff @(posedge clk) begin
    if (cmd.load_raw) begin
      rx0_r <= bx0; rx1_r <= bx1; ry0_r <= by0; ry1_r <= by1;
      rcol_r <= bcol;
      ren_r  <= en && (bcol != COLOR_NONE);
    end
  end

  // stage 2: clamp to screen and clip
  logic signed [13:0] kx0, kx1, ky0, ky1, clr, clb;
  logic               clip_on;

  always_comb begin
    clip_on = (clip_width_r != 0) && (clip_height_r != 0);
    clr = 14'(clip_left_r) + 14'(clip_width_r) - 14'sd1;
    clb = 14'(clip_top_r) + 14'(clip_height_r) - 14'sd1;
    kx0 = (rx0_r < 0) ? 14'sd0 : rx0_r;
    ky0 = (ry0_r < 0) ? 14'sd0 : ry0_r;
    kx1 = (rx1_r > XMAX) ? XMAX : rx1_r;
    ky1 = (ry1_r > YMAX) ? YMAX : ry1_r;
    if (clip_on) begin
      if (kx0 < 14'(clip_left_r)) kx0 = 14'(clip_left_r);
      if (ky0 < 14'(clip_top_r))  ky0 = 14'(clip_top_r);
      if (kx1 > clr) kx1 = clr;
      if (ky1 > clb) ky1 = clb;
    end
  end

  logic [CW-1:0] x1_r, col_r;
  logic [RW-1:0] y0_r, y1_r;
  logic [PW-1:0] page_r, pstart, pend;
  logic [1:0]    col_sel_r;
  logic          empty_r;

  assign pstart = PW'(y0_r >> 3);
  assign pend   = PW'(y1_r >> 3);

  always_ff @(posedge clk) begin
    if (cmd.load_full) begin
      x1_r <= CW'(SCREEN_COLUMNS - 1);
      y0_r <= '0; y1_r <= RW'(SCREEN_ROWS - 1);
      col_r <= '0; page_r <= '0;
    end else if (cmd.load_box) begin
      x1_r <= CW'(kx1);
      y0_r <= RW'(ky0); y1_r <= RW'(ky1);
      col_r <= CW'(kx0); page_r <= PW'(RW'(ky0) >> 3);
      col_sel_r <= rcol_r;
      empty_r <= !ren_r || (kx0 > kx1) || (ky0 > ky1);
    end else if (cmd.advance) begin
      if (page_r == pend) begin
        page_r <= pstart;
        col_r  <= col_r + 1'b1;
      end else begin
        page_r <= page_r + 1'b1;
      end
    end
  end

  assign status.box_empty = empty_r;
  assign status.walk_last = (col_r == x1_r) && (page_r == pend);

  // byte mask for the current page
  logic [2:0] lo, hi;
  logic [7:0] mask, q_r, wdata;
  always_comb begin
    lo = (page_r == pstart) ? y0_r[2:0] : 3'd0;
    hi = (page_r == pend)   ? y1_r[2:0] : 3'd7;
    for (int i = 0; i < 8; i++) mask[i] = (3'(i) >= lo) && (3'(i) <= hi);
    if (cmd.wr_zero)                  wdata = 8'h00;
    else if (col_sel_r == COLOR_WHITE) wdata = q_r | mask;
    else                              wdata = q_r & ~mask;
  end

  logic [AW-1:0]    waddr, raddr;
  logic [RAW_W-1:0] ext_addr;
  assign waddr    = AW'(page_r) * AW'(SCREEN_COLUMNS) + AW'(col_r);
  assign ext_addr = RAW_W'(addr_r);
  assign raddr    = cmd.rd_byte ? ext_addr[AW-1:0] : waddr;

  logic [7:0] mem [BYTES];
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[waddr] <= wdata;
    if (cmd.mem_rd || cmd.rd_byte) q_r <= mem[raddr];
  end

  assign out_read_data = rd_ok_r ? q_r : 8'h00;

endmodule

### rtl/pfrp_controller.sv
// Controller FSM: sequences boxes, byte read-modify-write, clear sweeps and byte reads.
// Depends on pfrp_pkg.
module pfrp_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_command,
  output logic                 busy,
  output logic                 out_strobe,
  output pfrp_pkg::dp_cmd_t    cmd,
  input  pfrp_pkg::dp_status_t status
);
  import pfrp_pkg::*;

  typedef enum logic [9:0] {
    ST_INIT  = 10'b0000000001,
    ST_WIPE  = 10'b0000000010,
    ST_IDLE  = 10'b0000000100,
    ST_RAW   = 10'b0000001000,
    ST_BOX   = 10'b0000010000,
    ST_CHECK = 10'b0000100000,
    ST_RD    = 10'b0001000000,
    ST_WR    = 10'b0010000000,
    ST_FETCH = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] sel_r, sel_nxt;
  logic       is_dot_r, is_dot_nxt;
  logic       reply_r, reply_nxt;   // wipe answers a request (not reset)
  logic       box_next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      sel_r    <= SEL_DOT;
      is_dot_r <= 1'b0;
      reply_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sel_r    <= sel_nxt;
      is_dot_r <= is_dot_nxt;
      reply_r  <= reply_nxt;
    end
  end

  assign box_next = is_dot_r || (sel_r == SEL_FILL);

  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    is_dot_nxt = is_dot_r;
    reply_nxt  = reply_r;
    cmd        = '0;
    cmd.box_sel = sel_r;
    case (state_r)
      ST_INIT: begin
        cmd.load_full = 1'b1;
        state_nxt = ST_WIPE;
      end
      ST_WIPE: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_zero = 1'b1;
        cmd.advance = 1'b1;
        if (status.walk_last) state_nxt = reply_r ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (in_command)
            CMD_DOT: begin
              is_dot_nxt = 1'b1; sel_nxt = SEL_DOT; state_nxt = ST_RAW;
            end
            CMD_RECT: begin
              is_dot_nxt = 1'b0; sel_nxt = SEL_LEFT; state_nxt = ST_RAW;
            end
            CMD_CLEAR: begin
              reply_nxt = 1'b1; state_nxt = ST_INIT;
            end
            default: state_nxt = ST_FETCH;
          endcase
        end
      end
      ST_RAW: begin
        cmd.load_raw = 1'b1;
        state_nxt = ST_BOX;
      end
      ST_BOX: begin
        cmd.load_box = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.box_empty) state_nxt = ST_RD;
        else if (box_next) state_nxt = ST_DONE;
        else begin
          sel_nxt = sel_r + 3'd1; state_nxt = ST_RAW;
        end
      end
      ST_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.mem_wr  = 1'b1;
        cmd.advance = 1'b1;
        if (!status.walk_last) state_nxt = ST_RD;
        else if (box_next) state_nxt = ST_DONE;
        else begin
          sel_nxt = sel_r + 3'd1; state_nxt = ST_RAW;
        end
      end
      ST_FETCH: begin
        cmd.rd_byte = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        reply_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = (state_r == ST_DONE);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy) else $error("result strobe not single");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> busy) else $error("accepted request left block idle");
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_wr && (cmd.mem_rd || cmd.rd_byte))) else $error("memory port conflict");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_wr && !cmd.wr_zero) |-> $past(cmd.mem_rd)) else $error("write without read");

endmodule
